// ===== design/tswm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tswm_pkg: shared types and constants for the two-way sorted merge
// Sizes of the list stores, request opcodes and the queue entry type that
// the front part hands to the back part.
// ----------------------------------------------------------------------------
package tswm_pkg;

	// list store geometry
	localparam int LIST_DEPTH = 16;
	localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
	localparam int DATA_W     = 32;
	localparam int MODE_W     = 2;

	// input mode codes
	localparam logic [MODE_W-1:0] MODE_PUSH_LEFT  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PUSH_RIGHT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_MERGE      = 2'd2;

	// classified operation carried through the queue
	typedef enum logic [1:0] {
		OP_PUSH_LEFT  = 2'd0,
		OP_PUSH_RIGHT = 2'd1,
		OP_MERGE      = 2'd2
	} op_t;

	// one queued request
	typedef struct packed {
		op_t                      op;
		logic signed [DATA_W-1:0] value;
	} req_t;

endpackage

// ===== design/two_way_sorted_merge_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_way_sorted_merge_top: merge of two ascending signed lists
// Loads a left and a right list one element per request, then a merge
// request streams out all stored elements in merged order.
// ----------------------------------------------------------------------------
// Mode 0 and 1 requests append value to the left or right list (up to
// LIST_DEPTH entries each; pushes to a full list are dropped and flagged);
// mode 2 emits every stored element, the left one first only when strictly
// smaller, marks the final result with last and then empties both lists;
// mode 3 is accepted and ignored. A merge emits one result per cycle while
// the output is not stalled, paced by the single read pointer per list and
// the one-deep output register. A two-entry request queue sits in front, so
// requests keep being accepted while a merge drains until that queue fills.
// A merge of two empty lists gives no result and only clears the overflow
// flag.
// ----------------------------------------------------------------------------
module two_way_sorted_merge_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [tswm_pkg::MODE_W-1:0]         mode,
	input  logic signed [tswm_pkg::DATA_W-1:0]  value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [tswm_pkg::DATA_W-1:0]  merged_value,
	output logic                                from_right,
	output logic                                last,
	output logic                                overflowed
);

	logic           q_valid;
	logic           q_pop;
	tswm_pkg::req_t q_req;

	// intake and classification
	tswm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.value    (value),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_req    (q_req)
	);

	// stores and merge sequencer
	tswm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_req        (q_req),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.merged_value (merged_value),
		.from_right   (from_right),
		.last         (last),
		.overflowed   (overflowed)
	);

endmodule

// ===== design/tswm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tswm_front: request intake and classification
// Accepts input requests, decodes the mode into an operation, drops unused
// mode codes and holds the rest in a two-entry queue for the back part.
// ----------------------------------------------------------------------------
module tswm_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [tswm_pkg::MODE_W-1:0]         mode,
	input  logic signed [tswm_pkg::DATA_W-1:0]  value,
	output logic                                q_valid,
	input  logic                                q_pop,
	output tswm_pkg::req_t                      q_req
);

	tswm_pkg::req_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           accept;
	logic           keep;
	logic           push;
	tswm_pkg::op_t  op_dec;

	// full queue holds off the upstream side
	assign in_stall = (cnt_q == 2'd2);
	assign accept   = in_valid && !in_stall;

	// classify the mode, unused codes are dropped
	always_comb begin
		op_dec = tswm_pkg::OP_MERGE;
		keep   = 1'b1;
		unique case (mode)
			tswm_pkg::MODE_PUSH_LEFT:  op_dec = tswm_pkg::OP_PUSH_LEFT;
			tswm_pkg::MODE_PUSH_RIGHT: op_dec = tswm_pkg::OP_PUSH_RIGHT;
			tswm_pkg::MODE_MERGE:      op_dec = tswm_pkg::OP_MERGE;
			default:                   keep   = 1'b0;
		endcase
	end

	assign push    = accept && keep;
	assign q_valid = (cnt_q != 2'd0);
	assign q_req   = entry_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= '{op: op_dec, value: value};
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

// ===== design/tswm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tswm_back: list stores and merge sequencer
// Executes queued requests: appends to the left or right store, or walks
// both stores with one read pointer each and emits the merged sequence.
// ----------------------------------------------------------------------------
module tswm_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_valid,
	input  tswm_pkg::req_t                      q_req,
	output logic                                q_pop,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [tswm_pkg::DATA_W-1:0]  merged_value,
	output logic                                from_right,
	output logic                                last,
	output logic                                overflowed
);

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_MERGE = 2'b10
	} state_t;

	state_t                             state_q;
	logic signed [tswm_pkg::DATA_W-1:0] left_mem_q  [tswm_pkg::LIST_DEPTH];
	logic signed [tswm_pkg::DATA_W-1:0] right_mem_q [tswm_pkg::LIST_DEPTH];
	logic signed [tswm_pkg::DATA_W-1:0] l_head_q;
	logic signed [tswm_pkg::DATA_W-1:0] r_head_q;
	logic [tswm_pkg::CNT_W-1:0]         lcnt_q;
	logic [tswm_pkg::CNT_W-1:0]         rcnt_q;
	logic [tswm_pkg::CNT_W-1:0]         li_q;
	logic [tswm_pkg::CNT_W-1:0]         ri_q;
	logic                               ovf_q;
	logic                               out_valid_q;
	logic signed [tswm_pkg::DATA_W-1:0] out_value_q;
	logic                               out_right_q;
	logic                               out_last_q;
	logic                               out_ovf_q;

	logic                               l_full;
	logic                               r_full;
	logic                               wr_left;
	logic                               wr_right;
	logic signed [tswm_pkg::DATA_W-1:0] l_elem;
	logic signed [tswm_pkg::DATA_W-1:0] r_elem;
	logic                               l_has;
	logic                               r_has;
	logic                               take_right;
	logic [tswm_pkg::CNT_W-1:0]         li_nxt;
	logic [tswm_pkg::CNT_W-1:0]         ri_nxt;
	logic [tswm_pkg::IDX_W-1:0]         l_rd_idx;
	logic [tswm_pkg::IDX_W-1:0]         r_rd_idx;
	logic                               is_last;
	logic                               out_free;
	logic                               emit;

	// requests are taken only between merges
	assign q_pop = (state_q == ST_IDLE) && q_valid;

	assign l_full   = (lcnt_q >= tswm_pkg::CNT_W'(tswm_pkg::LIST_DEPTH));
	assign r_full   = (rcnt_q >= tswm_pkg::CNT_W'(tswm_pkg::LIST_DEPTH));
	assign wr_left  = q_pop && (q_req.op == tswm_pkg::OP_PUSH_LEFT) && !l_full;
	assign wr_right = q_pop && (q_req.op == tswm_pkg::OP_PUSH_RIGHT) && !r_full;

	// head of each list and merge choice, ties go right
	assign l_elem = l_head_q;
	assign r_elem = r_head_q;
	assign l_has  = (li_q < lcnt_q);
	assign r_has  = (ri_q < rcnt_q);

	always_comb begin
		if (l_has && r_has) begin
			take_right = !(l_elem < r_elem);
		end else begin
			take_right = !l_has;
		end
	end

	assign li_nxt  = take_right ? li_q : li_q + tswm_pkg::CNT_W'(1);
	assign ri_nxt  = take_right ? ri_q + tswm_pkg::CNT_W'(1) : ri_q;
	assign is_last = (li_nxt == lcnt_q) && (ri_nxt == rcnt_q);

	// output register slot
	assign out_free = !out_valid_q || !out_stall;
	assign emit     = (state_q == ST_MERGE) && out_free;

	// head read address: first entry while idle, next head after each emitted result while merging
	always_comb begin
		l_rd_idx = '0;
		r_rd_idx = '0;
		if (state_q == ST_MERGE) begin
			l_rd_idx = emit ? li_nxt[tswm_pkg::IDX_W-1:0] : li_q[tswm_pkg::IDX_W-1:0];
			r_rd_idx = emit ? ri_nxt[tswm_pkg::IDX_W-1:0] : ri_q[tswm_pkg::IDX_W-1:0];
		end
	end

	// list stores with registered head reads
	always_ff @(posedge clk) begin
		if (wr_left) begin
			left_mem_q[lcnt_q[tswm_pkg::IDX_W-1:0]] <= q_req.value;
		end
		if (wr_right) begin
			right_mem_q[rcnt_q[tswm_pkg::IDX_W-1:0]] <= q_req.value;
		end
		l_head_q <= left_mem_q[l_rd_idx];
		r_head_q <= right_mem_q[r_rd_idx];
	end

	// sequencer, counts and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lcnt_q  <= '0;
			rcnt_q  <= '0;
			li_q    <= '0;
			ri_q    <= '0;
			ovf_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						unique case (q_req.op)
							tswm_pkg::OP_PUSH_LEFT: begin
								if (l_full) begin
									ovf_q <= 1'b1;
								end else begin
									lcnt_q <= lcnt_q + tswm_pkg::CNT_W'(1);
								end
							end
							tswm_pkg::OP_PUSH_RIGHT: begin
								if (r_full) begin
									ovf_q <= 1'b1;
								end else begin
									rcnt_q <= rcnt_q + tswm_pkg::CNT_W'(1);
								end
							end
							default: begin
								li_q <= '0;
								ri_q <= '0;
								if (lcnt_q == '0 && rcnt_q == '0) begin
									ovf_q <= 1'b0;
								end else begin
									state_q <= ST_MERGE;
								end
							end
						endcase
					end
				end
				ST_MERGE: begin
					if (emit) begin
						li_q <= li_nxt;
						ri_q <= ri_nxt;
						if (is_last) begin
							lcnt_q  <= '0;
							rcnt_q  <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_value_q <= take_right ? r_elem : l_elem;
			out_right_q <= take_right;
			out_last_q  <= is_last;
			out_ovf_q   <= ovf_q;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign merged_value = out_value_q;
	assign from_right   = out_right_q;
	assign last         = out_last_q;
	assign overflowed   = out_ovf_q;

endmodule

// ===== verif/tb_two_way_sorted_merge_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_way_sorted_merge_top: self-checking bench for the sorted merge
// Pushes left and right lists, issues merges and checks every merged element
// against an in-bench list model. A short directed table covers extremes,
// ties, ignored requests and a full list, then random list pairs follow,
// with random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_two_way_sorted_merge_top;

	localparam logic [tswm_pkg::MODE_W-1:0] MODE_IGNORED = 2'd3;
	localparam int REQUEST_TARGET = 310;
	localparam logic signed [tswm_pkg::DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
	localparam logic signed [tswm_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

	// one merged element as the block should emit it
	typedef struct packed {
		logic signed [tswm_pkg::DATA_W-1:0] elem;
		logic                               right;
		logic                               is_last;
		logic                               ovf;
	} merge_out_t;

	localparam merge_out_t NO_RESULT = '0;

	// one row of the directed table
	typedef struct packed {
		logic [tswm_pkg::MODE_W-1:0]        mode;
		logic signed [tswm_pkg::DATA_W-1:0] value;
		int                                 reps;
		bit                                 typed;
		merge_out_t                         want;
	} stim_row_t;

	localparam int N_ROWS = 24;

	// directed requests; typed rows carry the single result of a one-element merge
	stim_row_t stim_table [N_ROWS] = '{
		'{tswm_pkg::MODE_MERGE,      32'sd0,  1, 1'b0, NO_RESULT},
		'{tswm_pkg::MODE_PUSH_LEFT,  VAL_MAX, 1, 1'b0, NO_RESULT},
		'{tswm_pkg::MODE_MERGE,      32'sd0,  1, 1'b1, '{VAL_MAX, 1'b0, 1'b1, 1'b0}},
		'{tswm_pkg::MODE_PUSH_RIGHT, VAL_MIN, 1, 1'b0, NO_RESULT},
		'{tswm_pkg::MODE_MERGE,      32'sd0,  1, 1'b1, '{VAL_MIN, 1'b1, 1'b1, 1'b0}},
		'{tswm_pkg::MODE_PUSH_LEFT,  32'sd0,  1, 1'b0, NO_RESULT},
		'{tswm_pkg::MODE_PUSH_RIGHT, 32'sd0,  1, 1'b0, NO_RESULT},
		'{tswm_pkg::MODE_MERGE,      32'sd0,  1, 1'b0, NO_RESULT},
		'{tswm_pkg::MODE_PUSH_LEFT,  32'sd3,  1, 1'b0, NO_RESULT},
		'{MODE_IGNORED,              -32'sd1, 1, 1'b0, NO_RESULT},
		'{tswm_pkg::MODE_MERGE,      -32'sd1, 1, 1'b1, '{32'sd3, 1'b0, 1'b1, 1'b0}},
		'{tswm_pkg::MODE_PUSH_RIGHT, 32'sd7,  17, 1'b0, NO_RESULT},
		'{tswm_pkg::MODE_PUSH_LEFT,  -32'sd5, 1, 1'b0, NO_RESULT},
		'{tswm_pkg::MODE_MERGE,      32'sd0,  1, 1'b0, NO_RESULT},
		'{tswm_pkg::MODE_PUSH_RIGHT, 32'sd1,  1, 1'b0, NO_RESULT},
		'{tswm_pkg::MODE_MERGE,      32'sd0,  1, 1'b1, '{32'sd1, 1'b1, 1'b1, 1'b0}},
		'{tswm_pkg::MODE_PUSH_LEFT,  32'sd10, 1, 1'b0, NO_RESULT},
		'{tswm_pkg::MODE_PUSH_LEFT,  32'sd2,  1, 1'b0, NO_RESULT},
		'{tswm_pkg::MODE_PUSH_RIGHT, 32'sd5,  1, 1'b0, NO_RESULT},
		'{tswm_pkg::MODE_PUSH_RIGHT, -32'sd1, 1, 1'b0, NO_RESULT},
		'{tswm_pkg::MODE_MERGE,      VAL_MAX, 1, 1'b0, NO_RESULT},
		'{tswm_pkg::MODE_PUSH_LEFT,  VAL_MIN, 1, 1'b0, NO_RESULT},
		'{tswm_pkg::MODE_PUSH_RIGHT, VAL_MAX, 1, 1'b0, NO_RESULT},
		'{tswm_pkg::MODE_MERGE,      VAL_MIN, 1, 1'b0, NO_RESULT}
	};

	logic                               clk = 1'b0;
	logic                               arst_n;
	logic                               in_valid;
	logic                               in_stall;
	logic [tswm_pkg::MODE_W-1:0]        mode;
	logic signed [tswm_pkg::DATA_W-1:0] value;
	logic                               out_valid;
	logic                               out_stall = 1'b0;
	logic signed [tswm_pkg::DATA_W-1:0] merged_value;
	logic                               from_right;
	logic                               last;
	logic                               overflowed;

	// list model state
	logic signed [tswm_pkg::DATA_W-1:0] left_list [tswm_pkg::LIST_DEPTH];
	logic signed [tswm_pkg::DATA_W-1:0] right_list [tswm_pkg::LIST_DEPTH];
	int                                 left_len = 0;
	int                                 right_len = 0;
	bit                                 list_overflow = 1'b0;
	merge_out_t                         fresh_out [$];
	merge_out_t                         merge_expect [$];

	// run statistics
	int mismatches = 0;
	int payload_requests = 0;
	int results_checked = 0;
	int merges_done = 0;
	int overflow_merges = 0;

	// idle control
	bit in_calm = 1'b0;
	bit out_calm = 1'b0;
	int stall_hold = 0;
	int stall_pick;

	two_way_sorted_merge_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.value        (value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.merged_value (merged_value),
		.from_right   (from_right),
		.last         (last),
		.overflowed   (overflowed)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 40)
			$display("mismatch at %0t ns: %s", $realtime, what);
	endtask

	// list model: update state for one request, leave its results in fresh_out
	task automatic predict_request(input logic [tswm_pkg::MODE_W-1:0] m,
			input logic signed [tswm_pkg::DATA_W-1:0] v);
		int li;
		int ri;
		int total;
		merge_out_t r;
		li = 0;
		ri = 0;
		fresh_out.delete();
		case (m)
			tswm_pkg::MODE_PUSH_LEFT: begin
				if (left_len < tswm_pkg::LIST_DEPTH) begin
					left_list[left_len] = v;
					left_len++;
				end else
					list_overflow = 1'b1;
			end
			tswm_pkg::MODE_PUSH_RIGHT: begin
				if (right_len < tswm_pkg::LIST_DEPTH) begin
					right_list[right_len] = v;
					right_len++;
				end else
					list_overflow = 1'b1;
			end
			tswm_pkg::MODE_MERGE: begin
				total = left_len + right_len;
				for (int n = 0; n < total; n++) begin
					// left wins only when strictly smaller
					if (li < left_len && ri < right_len)
						r.right = !(left_list[li] < right_list[ri]);
					else
						r.right = (li >= left_len);
					if (r.right) begin
						r.elem = right_list[ri];
						ri++;
					end else begin
						r.elem = left_list[li];
						li++;
					end
					r.is_last = (n == total - 1);
					r.ovf = list_overflow;
					fresh_out.insert(fresh_out.size(), r);
				end
				merges_done++;
				if (list_overflow && total > 0)
					overflow_merges++;
				left_len = 0;
				right_len = 0;
				list_overflow = 1'b0;
			end
			default: ;
		endcase
	endtask

	function automatic int input_gap();
		int pick;
		if (in_calm)
			return 0;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		if (pick < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// drive one request and wait for it to be taken
	task automatic send_request(input logic [tswm_pkg::MODE_W-1:0] m,
			input logic signed [tswm_pkg::DATA_W-1:0] v, input bit typed,
			input merge_out_t want);
		int gap;
		gap = input_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		value <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_request(m, v);
		if (typed)
			merge_expect.insert(merge_expect.size(), want);
		else
			foreach (fresh_out[i]) merge_expect.insert(merge_expect.size(), fresh_out[i]);
		if (m != MODE_IGNORED)
			payload_requests++;
	endtask

	// next value of an ascending list, saturating at the top
	function automatic longint step_up(input longint cur, input bit narrow);
		longint nxt;
		if (narrow)
			nxt = cur + longint'($urandom_range(0, 2));
		else
			nxt = cur + longint'($urandom_range(0, 32'h0fff_ffff));
		if (nxt > 64'sd2147483647)
			nxt = 64'sd2147483647;
		return nxt;
	endfunction

	// load a left and a right list in random interleave, then merge
	task automatic run_list_pair(input int nl, input int nr, input bit narrow,
			input bit shuffled);
		logic signed [tswm_pkg::DATA_W-1:0] lq [$];
		logic signed [tswm_pkg::DATA_W-1:0] rq [$];
		longint cur_l;
		longint cur_r;
		logic signed [tswm_pkg::DATA_W-1:0] base;
		base = $urandom();
		cur_l = longint'(base);
		cur_r = narrow ? longint'(base) : longint'($signed($urandom()));
		for (int i = 0; i < nl; i++) begin
			lq.insert(lq.size(), shuffled ? $urandom() : cur_l[tswm_pkg::DATA_W-1:0]);
			cur_l = step_up(cur_l, narrow);
		end
		for (int i = 0; i < nr; i++) begin
			rq.insert(rq.size(), shuffled ? $urandom() : cur_r[tswm_pkg::DATA_W-1:0]);
			cur_r = step_up(cur_r, narrow);
		end
		while (lq.size() > 0 || rq.size() > 0) begin
			if ($urandom_range(0, 24) == 0)
				send_request(MODE_IGNORED, $urandom(), 1'b0, NO_RESULT);
			if (lq.size() > 0 && (rq.size() == 0 || $urandom_range(0, 1) == 1))
				send_request(tswm_pkg::MODE_PUSH_LEFT, lq.pop_front(), 1'b0, NO_RESULT);
			else
				send_request(tswm_pkg::MODE_PUSH_RIGHT, rq.pop_front(), 1'b0, NO_RESULT);
		end
		send_request(tswm_pkg::MODE_MERGE, $urandom(), 1'b0, NO_RESULT);
	endtask

	// hold requests back until every pending result has drained
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (merge_expect.size() == 0);
	endtask

	task automatic check_merge_out();
		merge_out_t want;
		if (merge_expect.size() == 0) begin
			report_mismatch($sformatf("result %0d with nothing pending", merged_value));
			return;
		end
		want = merge_expect.pop_front();
		results_checked++;
		if (merged_value !== want.elem)
			report_mismatch($sformatf("merged_value %0d, want %0d", merged_value, want.elem));
		if (from_right !== want.right)
			report_mismatch($sformatf("from_right %b, want %b (value %0d)",
				from_right, want.right, want.elem));
		if (last !== want.is_last)
			report_mismatch($sformatf("last %b, want %b (value %0d)",
				last, want.is_last, want.elem));
		if (overflowed !== want.ovf)
			report_mismatch($sformatf("overflowed %b, want %b (value %0d)",
				overflowed, want.ovf, want.elem));
	endtask

	// result side: check taken results, stall in random runs
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			check_merge_out();
		if (stall_hold > 0)
			stall_hold--;
		else if (out_calm) begin
			out_stall <= 1'b0;
			stall_hold = 8;
		end else begin
			stall_pick = $urandom_range(0, 99);
			if (stall_pick < 55) begin
				out_stall <= 1'b0;
				stall_hold = $urandom_range(0, 5);
			end else if (stall_pick < 92) begin
				out_stall <= 1'b1;
				stall_hold = $urandom_range(0, 2);
			end else begin
				out_stall <= 1'b1;
				stall_hold = $urandom_range(8, 30);
			end
		end
	end

	// main sequence
	initial begin
		int pick;
		int rounds;
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = tswm_pkg::MODE_PUSH_LEFT;
		value = '0;
		rounds = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (stim_table[i])
			for (int k = 0; k < stim_table[i].reps; k++)
				send_request(stim_table[i].mode, stim_table[i].value,
					stim_table[i].typed, stim_table[i].want);
		drain_results();

		// random list pairs
		while (payload_requests < REQUEST_TARGET) begin
			in_calm = ($urandom_range(0, 5) == 0);
			out_calm = ($urandom_range(0, 5) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 65)
				run_list_pair($urandom_range(0, 6), $urandom_range(0, 6),
					$urandom_range(0, 2) == 0, 1'b0);
			else if (pick < 80)
				run_list_pair($urandom_range(7, 16), $urandom_range(0, 16),
					$urandom_range(0, 2) == 0, 1'b0);
			else if (pick < 88)
				run_list_pair($urandom_range(14, 19), $urandom_range(14, 19),
					$urandom_range(0, 1) == 0, 1'b0);
			else if (pick < 94)
				run_list_pair($urandom_range(0, 8), $urandom_range(0, 8), 1'b0, 1'b1);
			else begin
				if ($urandom_range(0, 1) == 1)
					send_request(MODE_IGNORED, $urandom(), 1'b0, NO_RESULT);
				send_request(tswm_pkg::MODE_MERGE, $urandom(), 1'b0, NO_RESULT);
			end
			rounds++;
			if (rounds % 12 == 0)
				drain_results();
		end

		// wind down
		in_valid <= 1'b0;
		wait (merge_expect.size() == 0);
		repeat (40) @(posedge clk);
		$display("run covered %0d requests and %0d merges, %0d of them with dropped pushes",
			payload_requests, merges_done, overflow_merges);
		$display("%0d merged elements checked, %0d mismatches", results_checked, mismatches);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("timeout with %0d results still pending", merge_expect.size());
		$display("FAILURE");
		$finish;
	end

endmodule
